@@ hw/rtl/top_k_strongest_sources_defines.svh @@
// ----------------------------------------------------------------------------
// top_k_strongest_sources_defines.svh
// Assertion macros shared by the top-k source tracker modules
// ----------------------------------------------------------------------------
`ifndef TOP_K_STRONGEST_SOURCES_DEFINES_SVH
`define TOP_K_STRONGEST_SOURCES_DEFINES_SVH

// checked property, masked while reset is held
`define TKSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property, also during reset
`define TKSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/tkss_pkg.sv @@
// ----------------------------------------------------------------------------
// tkss_pkg
// Types and constants of the top-k strongest sources tracker
// ----------------------------------------------------------------------------
`default_nettype none

package tkss_pkg;

    localparam logic signed [7:0] EMPTY_STRENGTH = -8'sd101;

    typedef enum logic [1:0] {
        KIND_OBSERVE = 2'd0,
        KIND_READ    = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_RAISED   = 2'd1,
        ACT_INSERTED = 2'd2,
        ACT_DONE     = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_PLACE,
        ST_UPDATE,
        ST_CLEAR,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               filled;
        logic signed [7:0]  strength;
        logic [47:0]        mac;
        logic [31:0]        stamp;
    } t_slot;

    localparam t_slot EMPTY_SLOT = '{
        filled:   1'b0,
        strength: EMPTY_STRENGTH,
        mac:      48'd0,
        stamp:    32'd0
    };

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    scan_step;
        logic    place_init;
        logic    place_step;
        logic    update;
        logic    clear;
        logic    set_act;
        t_action act;
        logic    emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  hit;
        logic  found;
        logic  scan_last;
        logic  place_last;
        logic  better;
        logic  out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ hw/rtl/top_k_strongest_sources.sv @@
// ----------------------------------------------------------------------------
// top_k_strongest_sources
// Table of the strongest sources seen, kept sorted by signal strength
// ----------------------------------------------------------------------------
// One item is in work at a time. An observe item walks the table one slot a
// cycle through its single read port, looking for its MAC and the weakest
// slot and stopping early at its MAC. If it is stronger than the slot it
// would replace, it walks the table again for the insertion point before the
// whole table shifts in the update state. A read goes straight to the result;
// a clear empties the table first. The result sits in an output register, so
// the next item is taken while the previous result waits; a result load
// waits only while that register is still held by a stall.
`default_nettype none

module top_k_strongest_sources #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_kind,
    input  logic signed [7:0]   i_strength,
    input  logic [47:0]         i_source_mac,
    input  logic [31:0]         i_seen_time,
    input  logic [2:0]          i_read_rank,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_action,
    output logic [2:0]          o_rank,
    output logic                o_entry_valid,
    output logic signed [7:0]   o_entry_strength,
    output logic [47:0]         o_entry_mac,
    output logic [31:0]         o_entry_time
);
    import tkss_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    tkss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tkss_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_kind           (i_kind),
        .i_strength       (i_strength),
        .i_source_mac     (i_source_mac),
        .i_seen_time      (i_seen_time),
        .i_read_rank      (i_read_rank),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_action         (o_action),
        .o_rank           (o_rank),
        .o_entry_valid    (o_entry_valid),
        .o_entry_strength (o_entry_strength),
        .o_entry_mac      (o_entry_mac),
        .o_entry_time     (o_entry_time)
    );

endmodule

`default_nettype wire

@@ hw/rtl/tkss_ctrl.sv @@
// ----------------------------------------------------------------------------
// tkss_ctrl
// Sequencer of the top-k tracker: scan, decide, place, update, clear, emit
// ----------------------------------------------------------------------------
`default_nettype none
`include "top_k_strongest_sources_defines.svh"

module tkss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tkss_pkg::t_sts i_sts,
    output tkss_pkg::t_cmd o_cmd
);
    import tkss_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.act  = ACT_NONE;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.set_act = 1'b1;
                    case (i_sts.kind)
                        KIND_OBSERVE: begin
                            o_cmd.act = ACT_NONE;
                            n_state   = ST_SCAN;
                        end
                        KIND_READ: begin
                            o_cmd.act = ACT_DONE;
                            n_state   = ST_EMIT;
                        end
                        KIND_CLEAR: begin
                            o_cmd.act = ACT_DONE;
                            n_state   = ST_CLEAR;
                        end
                        default: begin
                            o_cmd.act = ACT_NONE;
                            n_state   = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.hit || i_sts.scan_last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.place_init = 1'b1;
                o_cmd.set_act    = 1'b1;
                if (i_sts.better) begin
                    o_cmd.act = i_sts.found ? ACT_RAISED : ACT_INSERTED;
                    n_state   = ST_PLACE;
                end else begin
                    o_cmd.act = ACT_NONE;
                    n_state   = ST_EMIT;
                end
            end
            ST_PLACE: begin
                o_cmd.place_step = 1'b1;
                if (i_sts.place_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `TKSS_ASSERT(a_emit_needs_room, i_clk, i_rst_n, o_cmd.emit |-> i_sts.out_free, "result loaded while output register is held")
    `TKSS_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "second transfer taken while an item is in work")
    `TKSS_ASSERT(a_update_then_emit, i_clk, i_rst_n, (r_state == ST_UPDATE) |=> (r_state == ST_EMIT), "table update not followed by result")

endmodule

`default_nettype wire

@@ hw/rtl/tkss_dp.sv @@
// ----------------------------------------------------------------------------
// tkss_dp
// Datapath of the top-k tracker: slot table, scan registers, output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "top_k_strongest_sources_defines.svh"

module tkss_dp #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tkss_pkg::t_cmd      i_cmd,
    output tkss_pkg::t_sts      o_sts,
    input  logic [1:0]          i_kind,
    input  logic signed [7:0]   i_strength,
    input  logic [47:0]         i_source_mac,
    input  logic [31:0]         i_seen_time,
    input  logic [2:0]          i_read_rank,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [1:0]          o_action,
    output logic [2:0]          o_rank,
    output logic                o_entry_valid,
    output logic signed [7:0]   o_entry_strength,
    output logic [47:0]         o_entry_mac,
    output logic [31:0]         o_entry_time
);
    import tkss_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] PLACE_END = IDX_W'(TABLE_ENTRIES - 2);

    t_slot              r_slot [TABLE_ENTRIES];
    t_slot              w_next [TABLE_ENTRIES];

    t_kind              r_kind;
    logic signed [7:0]  r_s;
    logic [47:0]        r_mac;
    logic [31:0]        r_t;
    logic [2:0]         r_rr;
    t_action            r_act;
    logic               r_found;
    logic [IDX_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_vic;
    logic signed [7:0]  r_vic_s;
    logic [IDX_W-1:0]   r_pos;

    logic               r_out_valid;
    logic [1:0]         r_o_action;
    logic [2:0]         r_o_rank;
    logic               r_o_valid;
    logic signed [7:0]  r_o_strength;
    logic [47:0]        r_o_mac;
    logic [31:0]        r_o_time;

    logic [IDX_W-1:0]   w_addr;
    t_slot              w_rd;
    t_slot              w_new;
    logic               w_hit;
    logic               w_rr_in;
    logic [7:0]         w_pos8;
    logic               w_out_free;

    t_action            w_res_action;
    logic [2:0]         w_res_rank;
    t_slot              w_res;

    // single table read port: scan slot, shifted slot while placing, else read rank
    always_comb begin
        if (i_cmd.place_step) begin
            w_addr = (r_cnt < r_vic) ? r_cnt : r_cnt + IDX_W'(1);
        end else if (i_cmd.scan_step) begin
            w_addr = r_cnt;
        end else begin
            w_addr = IDX_W'(r_rr);
        end
    end

    assign w_rd       = r_slot[w_addr];
    assign w_hit      = w_rd.filled && (w_rd.mac == r_mac);
    assign w_rr_in    = (8'(r_rr) < 8'(TABLE_ENTRIES));
    assign w_pos8     = 8'(r_pos);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_new = '{filled: 1'b1, strength: r_s, mac: r_mac, stamp: r_t};

    // each slot takes from itself, a neighbor or the new entry: remove victim, then put the new entry at r_pos
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_slot
        localparam int UP = (g + 1 < TABLE_ENTRIES) ? g + 1 : g;
        localparam int DN = (g > 0) ? g - 1 : g;
        localparam logic [IDX_W-1:0] SLOT_IDX = IDX_W'(g);
        localparam logic [IDX_W-1:0] DN_IDX   = IDX_W'(DN);

        always_comb begin
            if (SLOT_IDX < r_pos) begin
                w_next[g] = (SLOT_IDX < r_vic) ? r_slot[g] : r_slot[UP];
            end else if (SLOT_IDX == r_pos) begin
                w_next[g] = w_new;
            end else begin
                w_next[g] = (DN_IDX < r_vic) ? r_slot[DN] : r_slot[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_slot[i] <= EMPTY_SLOT;
            end
        end else if (i_cmd.update) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_slot[i] <= w_next[i];
            end
        end
    end

    // item registers and scan state
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= t_kind'(i_kind);
            r_s     <= i_strength;
            r_mac   <= i_source_mac;
            r_t     <= i_seen_time;
            r_rr    <= i_read_rank;
            r_found <= 1'b0;
            r_cnt   <= '0;
        end else if (i_cmd.scan_step) begin
            r_cnt <= r_cnt + IDX_W'(1);
            if (w_hit) begin
                r_found <= 1'b1;
                r_vic   <= r_cnt;
                r_vic_s <= w_rd.strength;
            end else if ((r_cnt == '0) || ($signed(w_rd.strength) < $signed(r_vic_s))) begin
                // lowest index holding the minimum
                r_vic   <= r_cnt;
                r_vic_s <= w_rd.strength;
            end
        end else if (i_cmd.place_init) begin
            r_cnt <= '0;
            r_pos <= '0;
        end else if (i_cmd.place_step) begin
            r_cnt <= r_cnt + IDX_W'(1);
            if ($signed(w_rd.strength) >= $signed(r_s)) begin
                r_pos <= r_cnt + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_act) begin
            r_act <= i_cmd.act;
        end
    end

    // result selection
    always_comb begin
        w_res_action = r_act;
        w_res_rank   = 3'd0;
        w_res        = EMPTY_SLOT;
        case (r_act)
            ACT_RAISED, ACT_INSERTED: begin
                w_res_rank = (w_pos8 > 8'd7) ? 3'd7 : w_pos8[2:0];
                w_res      = w_new;
            end
            ACT_DONE: begin
                if (r_kind == KIND_READ) begin
                    w_res_rank = r_rr;
                    if (w_rr_in) begin
                        w_res = w_rd;
                    end
                end
            end
            default: begin
                w_res = EMPTY_SLOT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_action   <= w_res_action;
            r_o_rank     <= w_res_rank;
            r_o_valid    <= w_res.filled;
            r_o_strength <= w_res.strength;
            r_o_mac      <= w_res.mac;
            r_o_time     <= w_res.stamp;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_o_action;
    assign o_rank           = r_o_rank;
    assign o_entry_valid    = r_o_valid;
    assign o_entry_strength = r_o_strength;
    assign o_entry_mac      = r_o_mac;
    assign o_entry_time     = r_o_time;

    always_comb begin
        o_sts            = '0;
        o_sts.kind       = t_kind'(i_kind);
        o_sts.hit        = w_hit;
        o_sts.found      = r_found;
        o_sts.scan_last  = (r_cnt == LAST_IDX);
        o_sts.place_last = (r_cnt == PLACE_END);
        o_sts.better     = ($signed(r_s) > $signed(r_vic_s));
        o_sts.out_free   = w_out_free;
    end

    `TKSS_ASSERT(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(i_cmd.emit), "output valid raised without a result load")
    `TKSS_ASSERT(a_head_sorted, i_clk, i_rst_n, $signed(r_slot[0].strength) >= $signed(r_slot[1].strength), "table head out of order")
    `TKSS_ASSERT(a_touched_valid, i_clk, i_rst_n, (i_cmd.emit && (r_act == ACT_RAISED || r_act == ACT_INSERTED)) |=> o_entry_valid, "touched entry reported as empty")

endmodule

`default_nettype wire
